>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ptts_pkg.sv
// Package with the types, codes and sizes of the periodic task tick scheduler.
`default_nettype none

package ptts_pkg;

    localparam int NUM_TASKS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(NUM_TASKS + 1);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 8;
    localparam int DELAY_W     = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;

    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
        logic               periodic;
        logic [DELAY_W-1:0] counter;
    } ptts_entry_t;

    typedef struct packed {
        logic shift_up;
        logic inc;
        logic remove;
        logic scan_tick;
        logic scan_stop;
    } ptts_cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptts_cell.sv
// One cell of the task chain: holds one entry and trades it with its neighbors.
`default_nettype none

module ptts_cell (
    input  wire                         clk,
    input  ptts_pkg::ptts_cell_ctl_t    ctl,
    input  wire [ptts_pkg::ID_W-1:0]    key,
    input  ptts_pkg::ptts_entry_t       lower_in,
    input  ptts_pkg::ptts_entry_t       upper_in,
    input  ptts_pkg::ptts_entry_t       tail_in,
    input  wire                         token_self,
    input  wire                         token_above,
    output ptts_pkg::ptts_entry_t       entry,
    output logic                        hit
);
    import ptts_pkg::*;

    ptts_entry_t entry_reg;
    ptts_entry_t entry_next;

    always_comb
    begin
        hit = token_self &
              ((ctl.scan_tick & (entry_reg.counter == entry_reg.delay)) |
               (ctl.scan_stop & (entry_reg.id == key)));
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_up)
        begin
            entry_next = lower_in;
        end
        else if (ctl.inc)
        begin
            entry_next.counter = entry_reg.counter + {{(DELAY_W-1){1'b0}}, 1'b1};
        end
        else if (ctl.remove)
        begin
            entry_next = token_above ? tail_in : upper_in;
        end
        else if (ctl.scan_tick && hit)
        begin
            entry_next.counter = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> hw/rtl/periodic_task_tick_scheduler_top.sv
// Top level of the periodic task tick scheduler: control, scan token and result path.
//
// Channel   Direction  Handshake                     Payload
// command   in         start high and busy low       mode, task_id, delay_ticks, periodic
// result    out        strobe high for one cycle     fired_id, status, last_of_run
//
// An add, a tick on an empty table or an unused mode leaves its word on the result
// ports in the next cycle. A tick or a stop on a table of n entries keeps busy high
// while the scan visits entries (at most n, at most NUM_TASKS) and while the run
// closes; the scan token walks the cell chain one or two cells a cycle. The last
// entry sits in cell zero, so removals shift the chain down.
// Reset clears the entry count, the state and the result strobe; the receiver cannot
// stall, so words leave at once.
`default_nettype none
`include "assert_macros.svh"

module periodic_task_tick_scheduler_top (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire [ptts_pkg::MODE_W-1:0]      mode,
    input  wire [ptts_pkg::ID_W-1:0]        task_id,
    input  wire [ptts_pkg::DELAY_W-1:0]     delay_ticks,
    input  wire                             periodic,
    output logic                            strobe,
    output logic [ptts_pkg::ID_W-1:0]       fired_id,
    output logic [ptts_pkg::STATUS_W-1:0]   status,
    output logic                            last_of_run
);
    import ptts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [NUM_TASKS-1:0]   token_reg, token_next;
    logic                   tick_mode_reg, tick_mode_next;
    logic [ID_W-1:0]        key_reg, key_next;
    logic                   found_reg, found_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]        pend_id_reg, pend_id_next;
    logic [RES_CNT_W-1:0]   rec_cnt_reg, rec_cnt_next;
    logic                   strobe_reg, strobe_next;
    logic [ID_W-1:0]        fired_id_reg, fired_id_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   last_reg, last_next;

    logic                   accept;
    logic                   table_full;
    logic [NUM_TASKS-1:0]   token_init;
    logic [NUM_TASKS-1:0]   hit_vec;
    logic                   any_hit;
    logic [ID_W-1:0]        hit_id;
    logic                   hit_periodic;
    ptts_cell_ctl_t         cell_ctl;
    ptts_entry_t            new_entry;
    ptts_entry_t            entry_arr [NUM_TASKS];
    ptts_entry_t            lower_arr [NUM_TASKS];
    ptts_entry_t            upper_arr [NUM_TASKS];
    logic [NUM_TASKS-1:0]   token_above;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start & (state_reg == S_IDLE);
    assign table_full = (count_reg >= CNT_W'(NUM_TASKS));

    assign new_entry.id       = task_id;
    assign new_entry.delay    = delay_ticks;
    assign new_entry.periodic = periodic;
    assign new_entry.counter  = '0;

    always_comb
    begin
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            token_init[k] = (count_reg == CNT_W'(k + 1));
        end
    end

    always_comb
    begin
        hit_id       = '0;
        hit_periodic = 1'b0;
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            hit_id       = hit_id | (hit_vec[k] ? entry_arr[k].id : '0);
            hit_periodic = hit_periodic | (hit_vec[k] & entry_arr[k].periodic);
        end
    end

    assign any_hit = |hit_vec;

    always_comb
    begin
        cell_ctl.shift_up  = accept && (mode == MODE_ADD) && !table_full;
        cell_ctl.inc       = accept && (mode == MODE_TICK);
        cell_ctl.scan_tick = (state_reg == S_SCAN) && tick_mode_reg;
        cell_ctl.scan_stop = (state_reg == S_SCAN) && !tick_mode_reg;
        cell_ctl.remove    = (state_reg == S_SCAN) && any_hit &&
                             (!tick_mode_reg || !hit_periodic);
    end

    for (genvar k = 0; k < NUM_TASKS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_bottom
            assign lower_arr[k] = new_entry;
        end
        else
        begin : g_lower
            assign lower_arr[k] = entry_arr[k-1];
        end

        if (k == NUM_TASKS - 1)
        begin : g_top
            assign upper_arr[k]   = '0;
            assign token_above[k] = 1'b0;
        end
        else
        begin : g_upper
            assign upper_arr[k]   = entry_arr[k+1];
            assign token_above[k] = token_reg[k+1];
        end

        ptts_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .key         (key_reg),
            .lower_in    (lower_arr[k]),
            .upper_in    (upper_arr[k]),
            .tail_in     (entry_arr[0]),
            .token_self  (token_reg[k]),
            .token_above (token_above[k]),
            .entry       (entry_arr[k]),
            .hit         (hit_vec[k])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        token_next      = token_reg;
        tick_mode_next  = tick_mode_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rec_cnt_next    = rec_cnt_reg;
        strobe_next     = 1'b0;
        fired_id_next   = '0;
        status_next     = ST_OK;
        last_next       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ADD:
                        begin
                            strobe_next = 1'b1;
                            if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        MODE_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next      = S_SCAN;
                                tick_mode_next  = 1'b1;
                                token_next      = token_init;
                                pend_valid_next = 1'b0;
                                rec_cnt_next    = '0;
                            end
                        end
                        MODE_STOP:
                        begin
                            state_next     = S_SCAN;
                            tick_mode_next = 1'b0;
                            token_next     = token_init;
                            found_next     = 1'b0;
                            key_next       = task_id;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (token_reg == '0)
                begin
                    state_next      = S_IDLE;
                    strobe_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    if (tick_mode_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            fired_id_next = pend_id_reg;
                            status_next   = ST_FIRED;
                        end
                    end
                    else
                    begin
                        status_next = found_reg ? ST_OK : ST_NOT_FOUND;
                    end
                end
                else
                begin
                    token_next = cell_ctl.remove ? (token_reg >> 2) : (token_reg >> 1);
                    if (cell_ctl.remove)
                    begin
                        count_next = count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                    if (any_hit && !tick_mode_reg)
                    begin
                        found_next = 1'b1;
                    end
                    if (any_hit && tick_mode_reg && (rec_cnt_reg < RES_CNT_W'(MAX_RESULTS)))
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_next   = 1'b1;
                            fired_id_next = pend_id_reg;
                            status_next   = ST_FIRED;
                            last_next     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = hit_id;
                        rec_cnt_next    = rec_cnt_reg + {{(RES_CNT_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            token_reg      <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            token_reg      <= token_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_mode_reg <= tick_mode_next;
        key_reg       <= key_next;
        found_reg     <= found_next;
        pend_id_reg   <= pend_id_next;
        rec_cnt_reg   <= rec_cnt_next;
        fired_id_reg  <= fired_id_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign strobe      = strobe_reg;
    assign fired_id    = fired_id_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    `ASSERT_ALWAYS(a_token_onehot, $onehot0(token_reg), "scan token is not one-hot")
    `ASSERT_ALWAYS(a_hit_onehot, $onehot0(hit_vec), "more than one cell reports a hit")
    `ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(NUM_TASKS), "entry count out of range")
    `ASSERT_IMPL(a_idle_no_pending, state_reg == S_IDLE, !pend_valid_reg, "pending word while idle")
    `ASSERT_NEXT(a_empty_tick, accept && (mode == MODE_TICK) && (count_reg == '0), strobe && (status == ST_EMPTY) && last_of_run, "empty tick did not report empty")

endmodule

`default_nettype wire
